// ===== design/dpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpc_pkg
// Types and constants shared by the differential pump controller modules.
// ----------------------------------------------------------------------------
package dpc_pkg;

    localparam int TEMP_W  = 12;
    localparam int DIFF_W  = 11;
    localparam int DELAY_W = 7;
    localparam int AVG_W   = 16;
    localparam int RISE_W  = 18;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ON_TEMP       = 3'd0,
        CFG_OFF_TEMP      = 3'd1,
        CFG_OVERHEAT_TEMP = 3'd2,
        CFG_DIFF_ON       = 3'd3,
        CFG_DIFF_OFF      = 3'd4,
        CFG_START_DELAY   = 3'd5,
        CFG_STOP_DELAY    = 3'd6
    } cfg_index_t;

    localparam logic signed [TEMP_W-1:0] ON_TEMP_RST       = 12'sd640;
    localparam logic signed [TEMP_W-1:0] OFF_TEMP_RST      = 12'sd320;
    localparam logic signed [TEMP_W-1:0] OVERHEAT_TEMP_RST = 12'sd1600;
    localparam logic [DIFF_W-1:0]        DIFF_ON_RST       = 11'd240;
    localparam logic [DIFF_W-1:0]        DIFF_OFF_RST      = 11'd80;
    localparam logic [DELAY_W-1:0]       START_DELAY_RST   = 7'd5;
    localparam logic [DELAY_W-1:0]       STOP_DELAY_RST    = 7'd60;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp_a;
        logic signed [TEMP_W-1:0] temp_b;
        logic                     sensors_ok;
    } in_item_t;

    typedef struct packed {
        logic               pump_on;
        logic               overheat_flag;
        logic               no_sensor_flag;
        logic [DELAY_W-1:0] countdown;
    } out_item_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] on_temp;
        logic signed [TEMP_W-1:0] off_temp;
        logic signed [TEMP_W-1:0] overheat_temp;
        logic [DIFF_W-1:0]        diff_on;
        logic [DIFF_W-1:0]        diff_off;
        logic [DELAY_W-1:0]       start_delay;
        logic [DELAY_W-1:0]       stop_delay;
    } cfg_t;

endpackage

// ===== design/dpc_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpc_cfg_regs
// Configuration register bank, written through a valid/ready channel.
// ----------------------------------------------------------------------------
module dpc_cfg_regs
    import dpc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TEMP_W-1:0]    cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid && cfg_ready;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_ON_TEMP:       cfg_next.on_temp       = $signed(cfg_data);
                CFG_OFF_TEMP:      cfg_next.off_temp      = $signed(cfg_data);
                CFG_OVERHEAT_TEMP: cfg_next.overheat_temp = $signed(cfg_data);
                CFG_DIFF_ON:       cfg_next.diff_on       = cfg_data[DIFF_W-1:0];
                CFG_DIFF_OFF:      cfg_next.diff_off      = cfg_data[DIFF_W-1:0];
                CFG_START_DELAY:   cfg_next.start_delay   = cfg_data[DELAY_W-1:0];
                CFG_STOP_DELAY:    cfg_next.stop_delay    = cfg_data[DELAY_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.on_temp       <= ON_TEMP_RST;
            cfg_reg.off_temp      <= OFF_TEMP_RST;
            cfg_reg.overheat_temp <= OVERHEAT_TEMP_RST;
            cfg_reg.diff_on       <= DIFF_ON_RST;
            cfg_reg.diff_off      <= DIFF_OFF_RST;
            cfg_reg.start_delay   <= START_DELAY_RST;
            cfg_reg.stop_delay    <= STOP_DELAY_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== design/dpc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpc_datapath
// Averages, start/stop conditions and switch countdown for one tick.
// ----------------------------------------------------------------------------
module dpc_datapath
    import dpc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t result
);

    logic signed [AVG_W-1:0]  hottest_avg_reg;
    logic signed [AVG_W-1:0]  hottest_avg_next;
    logic signed [RISE_W-1:0] rise_avg_reg;
    logic signed [RISE_W-1:0] rise_avg_next;
    logic                     pump_running_reg;
    logic                     pump_running_next;
    logic [DELAY_W-1:0]       countdown_reg;
    logic [DELAY_W-1:0]       countdown_next;

    logic signed [TEMP_W-1:0] hot;
    logic signed [AVG_W-1:0]  hot_scaled;
    logic [AVG_W:0]           avg_sum;
    logic [AVG_W:0]           rise;
    logic [RISE_W:0]          rise_sum;
    logic [TEMP_W:0]          delta;
    logic [TEMP_W:0]          delta_neg;
    logic [TEMP_W-1:0]        diff;
    logic                     overheat;
    logic                     rise_pos;
    logic                     start;
    logic                     stop;
    logic [DELAY_W-1:0]       start_load;
    logic [DELAY_W-1:0]       stop_load;
    logic [DELAY_W-1:0]       countdown_dec;

    assign hot        = (item.temp_a > item.temp_b) ? item.temp_a : item.temp_b;
    assign hot_scaled = $signed({hot, 4'b0000});

    // halving by arithmetic shift: drop the lsb of the widened sum
    assign avg_sum  = {hot_scaled[AVG_W-1], hot_scaled}
                    + {hottest_avg_reg[AVG_W-1], hottest_avg_reg};
    assign rise     = {hot_scaled[AVG_W-1], hot_scaled}
                    - {hottest_avg_reg[AVG_W-1], hottest_avg_reg};
    assign rise_sum = {{(RISE_W-AVG_W){rise[AVG_W]}}, rise}
                    + {rise_avg_reg[RISE_W-1], rise_avg_reg};

    assign hottest_avg_next = $signed(avg_sum[AVG_W:1]);
    assign rise_avg_next    = $signed(rise_sum[RISE_W:1]);

    assign delta     = {item.temp_a[TEMP_W-1], item.temp_a}
                     - {item.temp_b[TEMP_W-1], item.temp_b};
    assign delta_neg = '0 - delta;
    assign diff      = !item.sensors_ok ? '0 :
                       delta[TEMP_W] ? delta_neg[TEMP_W-1:0] : delta[TEMP_W-1:0];

    assign overheat = hot >= cfg.overheat_temp;
    assign rise_pos = !rise_avg_next[RISE_W-1] && (|rise_avg_next);

    assign start = overheat
                || ((diff > {1'b0, cfg.diff_on}) && rise_pos && (hot > cfg.on_temp));
    assign stop  = !overheat && !rise_pos
                && ((diff < {1'b0, cfg.diff_off}) || (hot < cfg.off_temp));

    assign start_load    = (cfg.start_delay == '0) ? DELAY_W'(1) : cfg.start_delay;
    assign stop_load     = (cfg.stop_delay == '0) ? DELAY_W'(1) : cfg.stop_delay;
    assign countdown_dec = countdown_reg - DELAY_W'(1);

    always_comb
    begin
        countdown_next    = countdown_reg;
        pump_running_next = pump_running_reg;
        if (countdown_reg == '0)
        begin
            if (start && !pump_running_reg)
                countdown_next = start_load;
            else if (stop && pump_running_reg)
                countdown_next = stop_load;
        end
        else
        begin
            countdown_next = countdown_dec;
            if (countdown_dec == '0)
            begin
                if (!pump_running_reg && start)
                    pump_running_next = 1'b1;
                else if (pump_running_reg && stop)
                    pump_running_next = 1'b0;
            end
        end
    end

    assign result.pump_on        = pump_running_next;
    assign result.overheat_flag  = overheat;
    assign result.no_sensor_flag = !item.sensors_ok;
    assign result.countdown      = countdown_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hottest_avg_reg  <= '0;
            rise_avg_reg     <= '0;
            pump_running_reg <= 1'b0;
            countdown_reg    <= '0;
        end
        else if (step)
        begin
            hottest_avg_reg  <= hottest_avg_next;
            rise_avg_reg     <= rise_avg_next;
            pump_running_reg <= pump_running_next;
            countdown_reg    <= countdown_next;
        end
    end

endmodule

// ===== design/differential_pump_controller_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_pump_controller_core
// Differential pump controller: one control tick in, one pump status out.
// ----------------------------------------------------------------------------
// Each request (two temperatures in 1/16 degree and a sensor flag) is held in
// an input register, evaluated combinationally against the running averages
// and the switch countdown, and the status lands in an output register. One
// request is taken per cycle when the output side does not stall; the
// result passes through the input and output registers and is held in the
// output register while the output side stalls. Configuration writes are
// always ready and should be made while no request is in flight.
module differential_pump_controller_core
    import dpc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_item,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TEMP_W-1:0]    cfg_data
);

    cfg_t      cfg;
    in_item_t  in_item_reg;
    logic      in_valid_reg;
    logic      in_valid_next;
    out_item_t out_item_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t result;
    logic      step;
    logic      in_take;

    dpc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dpc_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (result)
    );

    assign step     = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !step;
    assign in_take  = in_valid && !in_stall;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        priority if (in_take)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        priority if (step)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg <= in_item;
        end
        if (step)
        begin
            out_item_reg <= result;
        end
    end

endmodule
